/* rtl/frc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg
// Shared constants, types and the CRC-8 step for the frame receiver.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W       = 6;
    localparam int OUT_IDX_W   = 5;
    localparam int TDATA_W     = 32;

    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] CRC_INIT    = 8'h00;
    localparam logic [7:0] START_RESET = 8'h02;

    // register index decoded from paddr[2]
    localparam logic REG_START = 1'b0;

    typedef struct packed {
        logic load_cmd;     // latch command, seed CRC
        logic load_len;     // latch length, clear fill index
        logic store_byte;   // write payload byte, advance fill index
        logic start_emit;   // clear emit index
        logic rd_req;       // read payload store at emit index
        logic load_out;     // load output register, advance emit index
    } frc_cmd_t;

    typedef struct packed {
        logic start_hit;
        logic len_zero;
        logic len_over;
        logic data_done;
        logic crc_match;
        logic out_free;
        logic emit_last;
    } frc_sts_t;

    // MSB-first CRC-8, no reflection, no final xor
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* rtl/frc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

/* rtl/frc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_ctrl
// Frame phase state machine; drives datapath commands from status.
// ----------------------------------------------------------------------------
module frc_ctrl import frc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     in_ready,
    input  frc_sts_t sts,
    output frc_cmd_t cmd
);

    localparam logic [2:0] ST_WAIT    = 3'd0;
    localparam logic [2:0] ST_CMD     = 3'd1;
    localparam logic [2:0] ST_LEN     = 3'd2;
    localparam logic [2:0] ST_DATA    = 3'd3;
    localparam logic [2:0] ST_CRC     = 3'd4;
    localparam logic [2:0] ST_EMIT_RD = 3'd5;
    localparam logic [2:0] ST_EMIT_LD = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       fire;

    // take input in every receive phase, hold it off while emitting
    assign in_ready = (state_reg == ST_WAIT) || (state_reg == ST_CMD) ||
                      (state_reg == ST_LEN)  || (state_reg == ST_DATA) ||
                      (state_reg == ST_CRC);
    assign fire     = s_tvalid && in_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_WAIT: begin
                if (fire && sts.start_hit) state_next = ST_CMD;
            end
            ST_CMD: begin
                if (fire) begin
                    cmd.load_cmd = 1'b1;
                    state_next   = ST_LEN;
                end
            end
            ST_LEN: begin
                if (fire) begin
                    cmd.load_len = 1'b1;
                    if (sts.len_zero)      state_next = ST_CRC;
                    else if (sts.len_over) state_next = ST_WAIT;
                    else                   state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                if (fire) begin
                    cmd.store_byte = 1'b1;
                    if (sts.data_done) state_next = ST_CRC;
                end
            end
            ST_CRC: begin
                if (fire) begin
                    if (sts.crc_match) begin
                        cmd.start_emit = 1'b1;
                        state_next     = ST_EMIT_RD;
                    end else begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_EMIT_RD: begin
                // issue the read only when the output slot is free next cycle
                if (sts.out_free) begin
                    cmd.rd_req = 1'b1;
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                cmd.load_out = 1'b1;
                state_next   = sts.emit_last ? ST_WAIT : ST_EMIT_RD;
            end
            default: begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WAIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/frc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_datapath
// Held header fields, running CRC, payload store and output register.
// ----------------------------------------------------------------------------
module frc_datapath import frc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  frc_cmd_t           cmd,
    input  logic [7:0]         start_byte,
    input  logic [7:0]         rx_byte,
    input  logic               m_tready,
    output frc_sts_t           sts,
    output logic               m_tvalid,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    logic [7:0]           held_cmd_reg;
    logic [LEN_W-1:0]     held_len_reg;
    logic [LEN_W-1:0]     fill_idx_reg;
    logic [7:0]           crc_reg;
    logic [IDX_W-1:0]     emit_idx_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_cmd_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_has_reg;
    logic                 out_last_reg;

    logic [7:0]           crc_next;
    logic [7:0]           rd_data;
    logic                 has_payload;
    logic [LEN_W:0]       fill_plus1;
    logic [LEN_W-1:0]     emit_plus1;

    frc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.store_byte),
        .waddr (fill_idx_reg[IDX_W-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd_req),
        .raddr (emit_idx_reg),
        .rdata (rd_data)
    );

    assign crc_next    = crc8_update(cmd.load_cmd ? CRC_INIT : crc_reg, rx_byte);
    assign has_payload = (held_len_reg != '0);
    assign fill_plus1  = {1'b0, fill_idx_reg} + (LEN_W+1)'(1);
    assign emit_plus1  = LEN_W'(emit_idx_reg) + LEN_W'(1);

    always_comb begin
        sts.start_hit = (rx_byte == start_byte);
        sts.len_zero  = (rx_byte == 8'h00);
        sts.len_over  = (rx_byte > 8'(MAX_PAYLOAD));
        sts.data_done = (fill_plus1 >= {1'b0, held_len_reg});
        sts.crc_match = (crc_reg == rx_byte);
        sts.out_free  = !out_valid_reg || m_tready;
        sts.emit_last = !has_payload || (emit_plus1 == held_len_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cmd_reg  <= '0;
            held_len_reg  <= '0;
            fill_idx_reg  <= '0;
            crc_reg       <= CRC_INIT;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_cmd) held_cmd_reg <= rx_byte;
            if (cmd.load_len) begin
                held_len_reg <= rx_byte[LEN_W-1:0];
                fill_idx_reg <= '0;
            end
            if (cmd.store_byte) fill_idx_reg <= fill_idx_reg + LEN_W'(1);
            if (cmd.load_cmd || cmd.load_len || cmd.store_byte) crc_reg <= crc_next;
            if (cmd.start_emit) emit_idx_reg <= '0;
            else if (cmd.load_out) emit_idx_reg <= emit_idx_reg + IDX_W'(1);
            if (cmd.load_out) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_cmd_reg  <= held_cmd_reg;
            out_len_reg  <= held_len_reg;
            out_idx_reg  <= OUT_IDX_W'(emit_idx_reg);
            out_byte_reg <= has_payload ? rd_data : 8'h00;
            out_has_reg  <= has_payload;
            out_last_reg <= sts.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W-27)'(0), out_byte_reg, out_idx_reg, out_len_reg, out_cmd_reg};
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/frame_receiver_crc8.sv */
`timescale 1ns / 1ps
// Emission: the first result of a good frame is valid once its CRC byte is
//   accepted and the controller has passed ST_EMIT_RD and ST_EMIT_LD.
// Throughput: input is taken every cycle while a frame is received; during
//   emission input stalls and each result takes a store read then an output
//   load, and waits while the sink holds off m_tready.
// Reset: synchronous, active low; start_byte 0x02; store and output data not reset.
// ----------------------------------------------------------------------------
// frame_receiver_crc8
// Start/length framed byte receiver with CRC-8 (poly 0x07) check.
// ----------------------------------------------------------------------------
module frame_receiver_crc8 import frc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] frame_cmd, [13:8] frame_len,
                                          // [18:14] byte_index, [26:19] payload_byte
    output logic               m_tuser,   // [0] has_payload
    output logic               m_tlast,   // last result of the frame
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] start_byte_reg;
    logic       cfg_wr;
    frc_cmd_t   cmd;
    frc_sts_t   sts;

    // Register file: a single start byte register, selected when paddr[2] is 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_RESET;
        end else if (cfg_wr && (paddr[2] == REG_START)) begin
            // hold the low byte of the request data
            start_byte_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_START: prdata = {24'h000000, start_byte_reg};
            default:   prdata = 32'h0000_0000;
        endcase
    end

    // Controller: tracks the frame phase and sequences emission.
    frc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: header fields, running CRC, payload store, output register.
    frc_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .start_byte (start_byte_reg),
        .rx_byte    (s_tdata),
        .m_tready   (m_tready),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

/* rtl/frc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module frc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // hold a stalled result
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[26:14] == 13'h0000))
        else $error("zero-length result not a clean last");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> ({1'b0, m_tdata[18:14]} < m_tdata[13:8]))
        else $error("byte index beyond frame length");

    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a frame emission");

endmodule

bind frame_receiver_crc8 frc_checker u_frc_checker (.*);
